// ----- rtl/pwle_pkg.sv -----
// Package for the pulse-width line encoder with CRC-8.
// Holds the queue entry type, the register indexes and the CRC constants.
// No dependencies.
package pwle_pkg;

  localparam logic [7:0] CRC_POLY = 8'h85;
  localparam logic [7:0] CRC_INIT = 8'h00;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_US = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_CRC   = 1'd1;

  localparam logic [7:0] TICKS_PER_US_RESET = 8'd50;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       append;
    logic [7:0] crc;
  } job_t;

endpackage

// ----- rtl/pwle_front.sv -----
// Front end: accepts packet bytes, keeps the running CRC-8 and builds queue entries.
// Depends on pwle_pkg.
module pwle_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             invert_crc,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic             append_crc,
  input  logic             queue_full,
  output logic             push,
  output pwle_pkg::job_t   push_job
);

  logic [7:0] running_crc;
  logic [7:0] running_crc_next;
  logic [7:0] crc_new;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ pwle_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;
  assign crc_new  = crc_update(running_crc, data_byte);

  always_comb begin
    push_job.data   = data_byte;
    push_job.last   = last_byte;
    push_job.append = last_byte && append_crc;
    push_job.crc    = invert_crc ? ~crc_new : crc_new;
    running_crc_next = last_byte ? pwle_pkg::CRC_INIT : crc_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= pwle_pkg::CRC_INIT;
    end else if (push) begin
      running_crc <= running_crc_next;
    end
  end

endmodule

// ----- rtl/pwle_fifo.sv -----
// Short queue between front end and segment sequencer.
// Depends on pwle_pkg for the entry type.
module pwle_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pwle_pkg::job_t push_job,
  input  logic           pop,
  output pwle_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pwle_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

// ----- rtl/pwle_back.sv -----
// Segment sequencer: turns queue entries into timed line segments, one per unstalled cycle.
// Depends on pwle_pkg.
module pwle_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     ticks_per_us,
  input  logic           queue_empty,
  input  pwle_pkg::job_t queue_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           drive_low,
  output logic [9:0]     duration_ticks,
  output logic           last_segment
);

  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_CRC  = 2'd1;
  localparam logic [1:0] PH_STOP = 2'd2;

  localparam logic [1:0] US_1 = 2'd1;
  localparam logic [1:0] US_2 = 2'd2;
  localparam logic [1:0] US_3 = 2'd3;

  pwle_pkg::job_t job;
  logic           active;
  logic [1:0]     phase;
  logic [1:0]     phase_next;
  logic [3:0]     seg_idx;
  logic           take;
  logic           emit;
  logic           seg_low;
  logic [1:0]     seg_us;
  logic           seg_final;
  logic [9:0]     seg_ticks;
  logic [7:0]     cur_byte;
  logic           cur_bit;

  assign take = !out_valid || !out_stall;
  assign emit = active && take;

  always_comb begin
    cur_byte   = (phase == PH_CRC) ? job.crc : job.data;
    cur_bit    = cur_byte[~seg_idx[3:1]];
    seg_low    = !seg_idx[0];
    seg_us     = US_1;
    seg_final  = 1'b0;
    phase_next = phase;
    unique case (phase)
      PH_DATA, PH_CRC: begin
        seg_us = (cur_bit ^ seg_idx[0]) ? US_1 : US_3;
        if (seg_idx == 4'd15) begin
          if (phase == PH_CRC) begin
            phase_next = PH_STOP;
          end else if (job.last) begin
            phase_next = job.append ? PH_CRC : PH_STOP;
          end else begin
            seg_final = 1'b1;
          end
        end
      end
      PH_STOP: begin
        seg_us    = seg_idx[0] ? US_1 : US_2;
        seg_final = seg_idx[0];
      end
      default: begin
        seg_final = 1'b1;
      end
    endcase
    unique case (seg_us)
      US_2:    seg_ticks = {1'b0, ticks_per_us, 1'b0};
      US_3:    seg_ticks = {2'b00, ticks_per_us} + {1'b0, ticks_per_us, 1'b0};
      default: seg_ticks = {2'b00, ticks_per_us};
    endcase
    pop = emit ? (seg_final && !queue_empty) : (!active && !queue_empty);
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      drive_low      <= seg_low;
      duration_ticks <= seg_ticks;
      last_segment   <= seg_final;
    end
    if (pop) begin
      job <= queue_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      phase     <= PH_DATA;
      seg_idx   <= '0;
    end else begin
      if (take) begin
        out_valid <= active;
      end
      if (pop) begin
        active  <= 1'b1;
        phase   <= PH_DATA;
        seg_idx <= '0;
      end else if (emit && seg_final) begin
        active <= 1'b0;
      end else if (emit) begin
        phase   <= phase_next;
        seg_idx <= 4'(seg_idx + 1'b1);
      end
    end
  end

endmodule

// ----- rtl/pulse_width_line_encoder_crc8_top.sv -----
// Top level of the pulse-width line encoder with CRC-8.
// Instantiates pwle_front, pwle_fifo and pwle_back; depends on pwle_pkg.
//
// Each accepted byte becomes sixteen line segments (two per bit, MSB first); the segment
// sequencer hands out one segment per cycle unless stalled; a last byte adds two for the
// stop bit and sixteen more when the CRC byte is appended. The front end takes a new byte
// in any cycle that the queue of QUEUE_DEPTH entries has room, so bytes keep flowing while
// segments of earlier ones still go out. Durations are ticks_per_us times 1, 2 or 3.
// Configuration must be written by the user only while the block is idle; it is unchecked.
module pulse_width_line_encoder_crc8_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pwle_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pwle_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          data_byte,
  input  logic                                last_byte,
  input  logic                                append_crc,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                drive_low,
  output logic [9:0]                          duration_ticks,
  output logic                                last_segment
);

  logic [7:0]     ticks_per_us;
  logic           invert_crc;
  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_empty;
  pwle_pkg::job_t push_job;
  pwle_pkg::job_t queue_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= pwle_pkg::TICKS_PER_US_RESET;
      invert_crc   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pwle_pkg::REG_TICKS_PER_US: ticks_per_us <= cfg_data[7:0];
        pwle_pkg::REG_INVERT_CRC:   invert_crc   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pwle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .invert_crc (invert_crc),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .append_crc (append_crc),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  pwle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (queue_job),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  pwle_back u_back (
    .clk            (clk),
    .rst            (rst),
    .ticks_per_us   (ticks_per_us),
    .queue_empty    (queue_empty),
    .queue_job      (queue_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_low      (drive_low),
    .duration_ticks (duration_ticks),
    .last_segment   (last_segment)
  );

endmodule

// ----- rtl/pwle_checker.sv -----
// Port-level checks for the pulse-width line encoder, bound to the top level.
// Depends on pulse_width_line_encoder_crc8_top.
module pwle_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] data_byte,
  input logic       last_byte,
  input logic       append_crc,
  input logic       out_valid,
  input logic       out_stall,
  input logic       drive_low,
  input logic [9:0] duration_ticks,
  input logic       last_segment
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(data_byte) &&
      $stable(last_byte) && $stable(append_crc))
    else $error("stalled byte transfer changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive_low) &&
      $stable(duration_ticks) && $stable(last_segment))
    else $error("stalled segment transfer changed");

  a_reset_out_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("segment valid after reset");

  a_reset_in_ready: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");

  a_last_is_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_segment |-> !drive_low)
    else $error("final segment of a byte drives the line low");

endmodule

bind pulse_width_line_encoder_crc8_top pwle_checker u_pwle_checker (.*);

// ----- tb/tb.sv -----
// Testbench for pulse_width_line_encoder_crc8_top: drives packet bytes, predicts the
// line segments and the running CRC-8 byte, and checks every segment in order.
// Depends on pwle_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic       low;
    logic [9:0] ticks;
    logic       final_seg;
  } segment_t;

  logic                             clk        = 1'b0;
  logic                             rst        = 1'b1;
  logic                             cfg_write  = 1'b0;
  logic [pwle_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [pwle_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                             in_valid   = 1'b0;
  logic [7:0]                       data_byte  = '0;
  logic                             last_byte  = 1'b0;
  logic                             append_crc = 1'b0;
  logic                             out_stall  = 1'b0;
  logic                             in_stall;
  logic                             out_valid;
  logic                             drive_low;
  logic [9:0]                       duration_ticks;
  logic                             last_segment;

  segment_t   expected_segs[$];
  logic [7:0] line_ticks_per_us = pwle_pkg::TICKS_PER_US_RESET;
  logic       line_invert_crc   = 1'b0;
  logic [7:0] packet_crc        = 8'h00;
  int         mismatches        = 0;
  bit         idle_on           = 1'b1;
  int         stall_left        = 0;

  pulse_width_line_encoder_crc8_top dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte), .append_crc(append_crc),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive_low(drive_low), .duration_ticks(duration_ticks), .last_segment(last_segment)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ pwle_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic void push_segment(logic low, int unsigned us);
    segment_t seg;
    seg.low       = low;
    seg.ticks     = 10'((us * line_ticks_per_us) & 32'h3FF);
    seg.final_seg = 1'b0;
    expected_segs.push_back(seg);
  endfunction

  function automatic void push_bits(logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      push_segment(1'b1, b[i] ? 1 : 3);
      push_segment(1'b0, b[i] ? 3 : 1);
    end
  endfunction

  function automatic void predict_segments(logic [7:0] b, logic last, logic crc_req);
    segment_t seg;
    packet_crc = crc8_next(packet_crc, b);
    push_bits(b);
    if (last) begin
      if (crc_req) push_bits(line_invert_crc ? ~packet_crc : packet_crc);
      push_segment(1'b1, 2);
      push_segment(1'b0, 1);
      packet_crc = 8'h00;
    end
    seg = expected_segs.pop_back();
    seg.final_seg = 1'b1;
    expected_segs.push_back(seg);
  endfunction

  // Receive side: random stall bursts, check each segment transfer.
  always @(posedge clk) begin
    segment_t got;
    segment_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{drive_low, duration_ticks, last_segment};
        if (expected_segs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected segment: low=%0d ticks=%0d last=%0d",
                     got.low, got.ticks, got.final_seg);
        end else begin
          want = expected_segs.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want low=%0d ticks=%0d last=%0d got low=%0d ticks=%0d last=%0d",
                       want.low, want.ticks, want.final_seg,
                       got.low, got.ticks, got.final_seg);
          end
        end
      end
      if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 13);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last, logic crc_req);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    last_byte  <= last;
    append_crc <= crc_req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_segments(b, last, crc_req);
  endtask

  task automatic drain_segments();
    in_valid <= 1'b0;
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] ticks, logic invert);
    drain_segments();
    cfg_write <= 1'b1;
    cfg_index <= pwle_pkg::REG_TICKS_PER_US;
    cfg_data  <= ticks;
    @(posedge clk);
    cfg_index <= pwle_pkg::REG_INVERT_CRC;
    cfg_data  <= pwle_pkg::CFG_DATA_W'(invert);
    @(posedge clk);
    cfg_write <= 1'b0;
    line_ticks_per_us = ticks;
    line_invert_crc   = invert;
  endtask

  // Send one packet of random bytes; append_crc on inner bytes is noise.
  task automatic send_packet(int len, inout int sent);
    logic last;
    logic crc_req;
    for (int k = 0; k < len; k++) begin
      last    = (k == len - 1);
      crc_req = last ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
      send_byte(8'($urandom_range(0, 255)), last, crc_req);
      sent++;
    end
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_directed();
    set_config(8'd1, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'hA5, 1'b1, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b1, 1'b1);
    set_config(8'd255, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'h7E, 1'b1, 1'b0);
    send_byte(8'h12, 1'b1, 1'b1);
    set_config(8'd0, 1'b0);
    send_byte(8'h3C, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    set_config(8'd3, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_random_packets();
    int sent;
    logic [7:0] ticks;
    for (int phase = 0; phase < 6; phase++) begin
      unique case (phase)
        0:       ticks = 8'd1;
        1:       ticks = 8'd255;
        default: ticks = 8'($urandom_range(1, 255));
      endcase
      set_config(ticks, 1'($urandom_range(0, 1)));
      idle_on = (phase != 3);
      sent = 0;
      while (sent < 26) begin
        send_packet($urandom_range(1, 6), sent);
        // hold off until the line is quiet after each packet that leaves sent between 10 and 16
        if (phase == 2 && sent >= 10 && sent < 17) drain_segments();
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    int sent;
    set_config(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
    idle_on = 1'b0;
    sent = 0;
    while (sent < 20) send_packet($urandom_range(1, 5), sent);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed();
    test_random_packets();
    test_back_to_back();
    drain_segments();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- pulse_width_line_encoder_crc8_top.f -----
rtl/pwle_pkg.sv
rtl/pwle_front.sv
rtl/pwle_fifo.sv
rtl/pwle_back.sv
rtl/pulse_width_line_encoder_crc8_top.sv
rtl/pwle_checker.sv
tb/tb.sv
